FILE: design/priority_task_scheduler_macros.svh
// Assertion macros for the priority task scheduler.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pts_pkg.sv
// Package for the priority task scheduler: widths, codes and shared structs.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps

package pts_pkg;

   localparam int SLOT_FIELD_W     = 4;
   localparam int STATE_W          = 3;
   localparam int PRIO_W           = 32;
   localparam int OP_W             = 3;
   localparam int ERR_W            = 2;
   localparam int DEF_NUM_SLOTS    = 16;
   localparam int MAX_ACTIVE_SLOTS = 16;

   localparam logic [PRIO_W-1:0] PRIO_ALL_ONES  = '1;
   localparam logic [PRIO_W-1:0] PRIO_IDLE_INIT = PRIO_ALL_ONES - PRIO_W'(1);

   localparam logic [STATE_W-1:0] ST_FREE  = STATE_W'(0);
   localparam logic [STATE_W-1:0] ST_READY = STATE_W'(2);
   localparam logic [STATE_W-1:0] ST_TICK  = STATE_W'(3);

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 3'd0,
      OP_UART_OUT = 3'd1,
      OP_UART_IN  = 3'd2,
      OP_BLOCK    = 3'd3,
      OP_EXIT     = 3'd4,
      OP_WAKE     = 3'd5,
      OP_CREATE   = 3'd6,
      OP_RESCHED  = 3'd7
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_IDLE_EXIT = 2'd1,
      ERR_FULL      = 2'd2,
      ERR_NO_READY  = 2'd3
   } err_type;

   typedef struct packed {
      logic                    en;
      logic [SLOT_FIELD_W-1:0] slot;
   } tbl_rd_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [PRIO_W-1:0]  prio;
   } tbl_data_type;

   typedef struct packed {
      logic                    state_en;
      logic                    prio_en;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [STATE_W-1:0]      state;
      logic [PRIO_W-1:0]       prio;
   } tbl_wr_type;

   typedef struct packed {
      logic                    clear;
      logic                    sample;
      logic [STATE_W-1:0]      match_state;
      logic [SLOT_FIELD_W-1:0] slot;
   } scan_ctl_type;

   typedef struct packed {
      logic                    min_found;
      logic [SLOT_FIELD_W-1:0] min_slot;
      logic                    first_found;
      logic [SLOT_FIELD_W-1:0] first_slot;
   } scan_res_type;

endpackage

FILE: design/pts_req_if.sv
// Request channel of the priority task scheduler: valid/ready plus one operation.
// Depends on pts_pkg for field widths.
`timescale 1ns / 1ps

interface pts_req_if import pts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [SLOT_FIELD_W-1:0] target_slot;
   logic [STATE_W-1:0]      new_state;
   logic [PRIO_W-1:0]       new_priority;

   modport source (output valid, operation, target_slot, new_state, new_priority,
                   input ready);
   modport sink   (input valid, operation, target_slot, new_state, new_priority,
                   output ready);
endinterface

FILE: design/pts_rsp_if.sv
// Response channel of the priority task scheduler: valid/ready plus one result.
// Depends on pts_pkg for field widths.
`timescale 1ns / 1ps

interface pts_rsp_if import pts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SLOT_FIELD_W-1:0] running_slot;
   logic                    switched;
   logic [SLOT_FIELD_W-1:0] affected_slot;
   logic                    affected_valid;
   logic [ERR_W-1:0]        error_code;

   modport source (output valid, running_slot, switched, affected_slot,
                   affected_valid, error_code, input ready);
   modport sink   (input valid, running_slot, switched, affected_slot,
                   affected_valid, error_code, output ready);
endinterface

FILE: design/pts_csr_if.sv
// Configuration write channel of the priority task scheduler (idle slot register).
// Depends on pts_pkg for the data width.
`timescale 1ns / 1ps

interface pts_csr_if import pts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SLOT_FIELD_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/pts_table.sv
// Task table: synchronous state and priority memories, one read and one write port.
// Depends on pts_pkg; per-entry valid bits supply the reset contents.
`timescale 1ns / 1ps

module pts_table import pts_pkg::*; #(
   parameter int SLOTS  = MAX_ACTIVE_SLOTS,
   parameter int SLOT_W = $clog2(MAX_ACTIVE_SLOTS)
) (
   input  logic         clock,
   input  logic         reset,
   input  tbl_rd_type   rd,
   output tbl_data_type rd_data,
   input  tbl_wr_type   wr
);

   logic [STATE_W-1:0] state_mem [SLOTS];
   logic [PRIO_W-1:0]  prio_mem  [SLOTS];
   logic [SLOTS-1:0]   state_valid_ff;
   logic [SLOTS-1:0]   prio_valid_ff;

   logic [STATE_W-1:0] rd_state_ff;
   logic [PRIO_W-1:0]  rd_prio_ff;
   logic               rd_state_valid_ff;
   logic               rd_prio_valid_ff;
   logic               rd_slot_zero_ff;

   logic [SLOT_W-1:0]  wr_addr;
   logic [SLOT_W-1:0]  rd_addr;

   assign wr_addr = wr.slot[SLOT_W-1:0];
   assign rd_addr = rd.slot[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.state_en) begin
         state_mem[wr_addr] <= wr.state;
      end
      if (wr.prio_en) begin
         prio_mem[wr_addr] <= wr.prio;
      end
      if (rd.en) begin
         rd_state_ff       <= state_mem[rd_addr];
         rd_prio_ff        <= prio_mem[rd_addr];
         rd_state_valid_ff <= state_valid_ff[rd_addr];
         rd_prio_valid_ff  <= prio_valid_ff[rd_addr];
         rd_slot_zero_ff   <= (rd_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_valid_ff <= '0;
         prio_valid_ff  <= '0;
      end else begin
         if (wr.state_en) begin
            state_valid_ff[wr_addr] <= 1'b1;
         end
         if (wr.prio_en) begin
            prio_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // An entry never written reads as its reset contents: slot 0 is the ready
   // idle task, every other slot is free with an all-ones priority.
   always_comb begin
      rd_data.state = rd_state_valid_ff ? rd_state_ff :
                      (rd_slot_zero_ff ? ST_READY : ST_FREE);
      rd_data.prio  = rd_prio_valid_ff ? rd_prio_ff :
                      (rd_slot_zero_ff ? PRIO_IDLE_INIT : PRIO_ALL_ONES);
   end

endmodule

FILE: design/pts_scan.sv
// Scan accumulator: minimum priority and first slot among entries in one state.
// Depends on pts_pkg; fed one table entry per cycle by the sequencer.
`timescale 1ns / 1ps

module pts_scan import pts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  scan_ctl_type ctl,
   input  tbl_data_type entry,
   output scan_res_type res
);

   logic [PRIO_W-1:0]       best_prio_ff;
   logic [SLOT_FIELD_W-1:0] best_slot_ff;
   logic                    first_found_ff;
   logic [SLOT_FIELD_W-1:0] first_slot_ff;
   logic                    is_match;

   assign is_match = ctl.sample && (entry.state == ctl.match_state);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         best_prio_ff   <= PRIO_ALL_ONES;
         best_slot_ff   <= '0;
         first_found_ff <= 1'b0;
         first_slot_ff  <= '0;
      end else begin
         // Strict compare keeps the lower slot on a tie and never picks all ones.
         if (is_match && (entry.prio < best_prio_ff)) begin
            best_prio_ff <= entry.prio;
            best_slot_ff <= ctl.slot;
         end
         if (is_match && !first_found_ff) begin
            first_found_ff <= 1'b1;
            first_slot_ff  <= ctl.slot;
         end
      end
   end

   assign res.min_found   = (best_prio_ff != PRIO_ALL_ONES);
   assign res.min_slot    = best_slot_ff;
   assign res.first_found = first_found_ff;
   assign res.first_slot  = first_slot_ff;

endmodule

FILE: design/priority_task_scheduler.sv
// Priority task scheduler top level: request sequencer, table and scan unit.
// Depends on pts_pkg, the three channel interfaces, pts_table, pts_scan and the
// assertion macro header.
//
// Usage: one request on req_chan carries an operation (event, block, exit, wake,
// create or reschedule); exactly one response follows on rsp_chan with the running
// slot, a switch flag, the affected slot and an error code. csr_chan writes the
// idle slot register; it is always ready and should be written only while idle.
// Throughput: one request at a time. Each table scan walks the memory read port
// one slot per cycle over S = min(NUM_SLOTS, 16) active slots. Wake and a refused
// exit of the idle slot need no scan; block, exit, create (a refused create too)
// and reschedule need one scan; an event needs two, one for the waiter and then
// a reschedule. The response appears in the same cycle as the sequencer becomes
// ready for the next request.
// Reset: slot 0 holds the ready idle task, all other slots are free, the running
// slot and the idle slot register are 0; the table needs no clearing pass.
// Stalls: the response sits in an output register. A stalled receiver does not
// block the next request, which is taken and worked on, but that request waits in
// the final state, with req_chan.ready low, until the register drains.
`timescale 1ns / 1ps

`include "priority_task_scheduler_macros.svh"

module priority_task_scheduler import pts_pkg::*; #(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   pts_req_if.sink   req_chan,
   pts_rsp_if.source rsp_chan,
   pts_csr_if.sink   csr_chan
);

   // Only the first sixteen slots can be named by the 4-bit slot fields.
   localparam int ACTIVE_SLOTS = (NUM_SLOTS < MAX_ACTIVE_SLOTS) ? NUM_SLOTS
                                                               : MAX_ACTIVE_SLOTS;
   localparam int SLOT_W = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(ACTIVE_SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } fsm_type;

   fsm_type                 state_ff;
   op_type                  op_ff;
   logic [STATE_W-1:0]      new_state_ff;
   logic [PRIO_W-1:0]       new_prio_ff;
   logic [SLOT_W-1:0]       cur_ff;
   logic [SLOT_W-1:0]       before_ff;
   logic [SLOT_FIELD_W-1:0] idle_slot_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    rd_pend_ff;
   logic [SLOT_W-1:0]       rd_idx_ff;
   logic                    resched_ff;   // reschedule scan phase: pick the next task
   logic [STATE_W-1:0]      match_ff;
   logic [SLOT_FIELD_W-1:0] aff_slot_ff;
   logic                    aff_valid_ff;
   err_type                 err_ff;

   logic                    rsp_valid_ff;
   logic [SLOT_FIELD_W-1:0] rsp_running_ff;
   logic                    rsp_switched_ff;
   logic [SLOT_FIELD_W-1:0] rsp_aff_slot_ff;
   logic                    rsp_aff_valid_ff;
   err_type                 rsp_err_ff;

   logic         req_fire;
   logic         scan_done;
   logic         cur_is_idle;
   logic         tgt_in_range;
   op_type       req_op;
   tbl_rd_type   tbl_rd;
   tbl_data_type tbl_data;
   tbl_wr_type   tbl_wr;
   scan_ctl_type scan_ctl;
   scan_res_type scan_res;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_op         = op_type'(req_chan.operation);
   assign cur_is_idle    = (SLOT_FIELD_W'(cur_ff) == idle_slot_ff);
   assign tgt_in_range   = ({1'b0, req_chan.target_slot} <
                            (SLOT_FIELD_W + 1)'(ACTIVE_SLOTS));

   // A scan has finished when every slot has been read and the last read sampled.
   assign scan_done = (state_ff == S_SCAN) && (cnt_ff == CNT_W'(ACTIVE_SLOTS)) &&
                      !rd_pend_ff;

   // Table reads are issued only while scanning, never in a cycle with a write.
   assign tbl_rd.en   = (state_ff == S_SCAN) && (cnt_ff < CNT_W'(ACTIVE_SLOTS));
   assign tbl_rd.slot = SLOT_FIELD_W'(cnt_ff);

   // Table writes: state updates at request acceptance, and the outcome of the
   // first scan (an event waiter made ready, or a new task in the first free slot).
   always_comb begin
      tbl_wr = '0;
      if (req_fire) begin
         case (req_op) inside
            OP_BLOCK: begin
               tbl_wr.state_en = 1'b1;
               tbl_wr.slot     = SLOT_FIELD_W'(cur_ff);
               tbl_wr.state    = req_chan.new_state;
            end
            OP_EXIT: begin
               tbl_wr.state_en = !cur_is_idle;
               tbl_wr.slot     = SLOT_FIELD_W'(cur_ff);
               tbl_wr.state    = ST_FREE;
            end
            OP_WAKE: begin
               tbl_wr.state_en = tgt_in_range;
               tbl_wr.slot     = req_chan.target_slot;
               tbl_wr.state    = ST_READY;
            end
            default: begin
            end
         endcase
      end
      if (scan_done && !resched_ff) begin
         case (op_ff) inside
            OP_TICK, OP_UART_OUT, OP_UART_IN: begin
               tbl_wr.state_en = scan_res.min_found;
               tbl_wr.slot     = scan_res.min_slot;
               tbl_wr.state    = ST_READY;
            end
            OP_CREATE: begin
               tbl_wr.state_en = scan_res.first_found;
               tbl_wr.prio_en  = scan_res.first_found;
               tbl_wr.slot     = scan_res.first_slot;
               tbl_wr.state    = new_state_ff;
               tbl_wr.prio     = new_prio_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // The scan restarts on every accepted request and before the reschedule
   // that follows an event scan.
   always_comb begin
      scan_ctl.clear       = req_fire ||
                             (scan_done && !resched_ff &&
                              (op_ff == OP_TICK || op_ff == OP_UART_OUT ||
                               op_ff == OP_UART_IN));
      scan_ctl.sample      = rd_pend_ff;
      scan_ctl.match_state = match_ff;
      scan_ctl.slot        = SLOT_FIELD_W'(rd_idx_ff);
   end

   pts_table #(
      .SLOTS  (ACTIVE_SLOTS),
      .SLOT_W (SLOT_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd      (tbl_rd),
      .rd_data (tbl_data),
      .wr      (tbl_wr)
   );

   pts_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .entry (tbl_data),
      .res   (scan_res)
   );

   // Idle slot register; the channel never stalls.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_slot_ff <= '0;
      end else if (csr_chan.valid) begin
         idle_slot_ff <= csr_chan.data;
      end
   end

   // Sequencer: holds the request, steps the scans and loads the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         resched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= tbl_rd.en;
         rd_idx_ff  <= cnt_ff[SLOT_W-1:0];
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff        <= req_op;
                  new_state_ff <= req_chan.new_state;
                  new_prio_ff  <= req_chan.new_priority;
                  before_ff    <= cur_ff;
                  aff_slot_ff  <= '0;
                  aff_valid_ff <= 1'b0;
                  err_ff       <= ERR_OK;
                  cnt_ff       <= '0;
                  resched_ff   <= 1'b1;
                  match_ff     <= ST_READY;
                  state_ff     <= S_SCAN;
                  case (req_op) inside
                     OP_TICK, OP_UART_OUT, OP_UART_IN: begin
                        resched_ff <= 1'b0;
                        match_ff   <= STATE_W'(ST_TICK + STATE_W'(req_op));
                     end
                     OP_EXIT: begin
                        if (cur_is_idle) begin
                           err_ff   <= ERR_IDLE_EXIT;
                           state_ff <= S_DONE;
                        end
                     end
                     OP_WAKE: begin
                        aff_slot_ff  <= tgt_in_range ? req_chan.target_slot : '0;
                        aff_valid_ff <= tgt_in_range;
                        state_ff     <= S_DONE;
                     end
                     OP_CREATE: begin
                        resched_ff <= 1'b0;
                        match_ff   <= ST_FREE;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (tbl_rd.en) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
               if (scan_done) begin
                  if (resched_ff) begin
                     if (scan_res.min_found) begin
                        cur_ff <= scan_res.min_slot[SLOT_W-1:0];
                     end else begin
                        err_ff <= ERR_NO_READY;
                     end
                     state_ff <= S_DONE;
                  end else if (op_ff == OP_CREATE) begin
                     if (scan_res.first_found) begin
                        aff_slot_ff  <= scan_res.first_slot;
                        aff_valid_ff <= 1'b1;
                     end else begin
                        err_ff <= ERR_FULL;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     // Event: the waiter (if any) was written ready this cycle;
                     // the reschedule scan starts reading on the next.
                     if (scan_res.min_found) begin
                        aff_slot_ff  <= scan_res.min_slot;
                        aff_valid_ff <= 1'b1;
                     end
                     resched_ff <= 1'b1;
                     match_ff   <= ST_READY;
                     cnt_ff     <= '0;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_running_ff   <= SLOT_FIELD_W'(cur_ff);
                  rsp_switched_ff  <= (cur_ff != before_ff);
                  rsp_aff_slot_ff  <= aff_slot_ff;
                  rsp_aff_valid_ff <= aff_valid_ff;
                  rsp_err_ff       <= err_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.running_slot   = rsp_running_ff;
   assign rsp_chan.switched       = rsp_switched_ff;
   assign rsp_chan.affected_slot  = rsp_aff_slot_ff;
   assign rsp_chan.affected_valid = rsp_aff_valid_ff;
   assign rsp_chan.error_code     = rsp_err_ff;

   // A request, once taken, moves the sequencer out of idle, so req_chan.ready drops behind it.
   `PTS_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_chan.ready, "request accepted while busy")

   // Scan reads and table writes never share a cycle, so no read sees a stale entry.
   `PTS_ASSERT_SAME(a_no_rd_wr_overlap, tbl_rd.en, !(tbl_wr.state_en || tbl_wr.prio_en), "table read overlaps a write")

   // A refused idle exit changes nothing.
   `PTS_ASSERT_SAME(a_idle_exit_quiet, rsp_chan.valid && (rsp_chan.error_code == ERR_IDLE_EXIT), !rsp_chan.switched && !rsp_chan.affected_valid, "refused exit reported a change")

endmodule
